/* hdl/ptc_pkg.sv */
// shared constants for the pressure and temperature compensation block
package ptc_pkg;

  localparam int RAW_W     = 20;
  localparam int TEMP_W    = 32;
  localparam int PRESS_W   = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_BITS  = 64;
  localparam int DIV_SHIFT = 33;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_TEMP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_C = 2'd3;

  localparam logic signed [32:0] TEMP_OFFSET = 33'sd128000;
  localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
  localparam logic [11:0]        PRESS_SCALE = 12'd3125;
  localparam logic [63:0]        PRESS_ONE   = 64'h0000_8000_0000_0000;

endpackage

/* hdl/ptc_if.sv */
// request and result channel interfaces
interface ptc_sample_if;
  logic                        valid;
  logic                        ready;
  logic [ptc_pkg::RAW_W-1:0]   raw_temperature;
  logic [ptc_pkg::RAW_W-1:0]   raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface ptc_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [ptc_pkg::TEMP_W-1:0] temperature_centi;
  logic [ptc_pkg::PRESS_W-1:0]       pressure_q24_8;
  logic                              pressure_invalid;
  modport source (output valid, temperature_centi, pressure_q24_8, pressure_invalid,
                  input ready);
  modport sink (input valid, temperature_centi, pressure_q24_8, pressure_invalid,
                output ready);
endinterface

/* hdl/pressure_temperature_compensation.sv */
// top level: pipelined integer compensation of temperature and pressure
//
//   channel   dir  handshake      payload
//   sample    in   valid/ready    raw_temperature, raw_pressure
//   result    out  valid/ready    temperature_centi, pressure_q24_8, pressure_invalid
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// one request per cycle while the pipeline is not stalled; 79 pipeline stages plus
// the output register, of which 64 are the one-bit-per-stage restoring divider.
// rst is synchronous and clears calibration, stage valid bits and the output valid.
// the pipeline advances while its last stage is empty or the output can move;
// a stall holds every stage in place.
module pressure_temperature_compensation (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptc_pkg::CFG_W-1:0]      cfg_data,
  ptc_sample_if.sink                     sample,
  ptc_result_if.source                   result
);

  localparam int S_T4 = 3;
  localparam int S_P4 = 7;
  localparam int S_P6 = 9;
  localparam int S_D0 = 10;
  localparam int S_DL = S_D0 + ptc_pkg::DIV_BITS - 1;
  localparam int NST  = S_DL + 6;

  // calibration
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [15:0] cal_press_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp    <= '0;
      cal_press_a <= '0;
      cal_press_b <= '0;
      cal_press_c <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptc_pkg::CFG_CAL_TEMP:    cal_temp    <= cfg_data[47:0];
        ptc_pkg::CFG_CAL_PRESS_A: cal_press_a <= cfg_data;
        ptc_pkg::CFG_CAL_PRESS_B: cal_press_b <= cfg_data;
        ptc_pkg::CFG_CAL_PRESS_C: cal_press_c <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = cal_temp[15:0];
  assign t2 = $signed(cal_temp[31:16]);
  assign t3 = $signed(cal_temp[47:32]);
  assign p1 = cal_press_a[15:0];
  assign p2 = $signed(cal_press_a[31:16]);
  assign p3 = $signed(cal_press_a[47:32]);
  assign p4 = $signed(cal_press_a[63:48]);
  assign p5 = $signed(cal_press_b[15:0]);
  assign p6 = $signed(cal_press_b[31:16]);
  assign p7 = $signed(cal_press_b[47:32]);
  assign p8 = $signed(cal_press_b[63:48]);
  assign p9 = $signed(cal_press_c);

  // flow control
  logic [NST-1:0] vld;
  logic           res_valid;
  logic           out_move;
  logic           en;

  assign out_move     = !res_valid || result.ready;
  assign en           = !vld[NST-1] || out_move;
  assign sample.ready = en;
  assign result.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], sample.valid};
    end
  end

  // temperature stage 1: differences and first products
  logic signed [18:0] d1;
  logic signed [17:0] d2;
  logic signed [34:0] m1_full;
  logic signed [35:0] sq_full;
  logic [31:0]        s1_m1;
  logic [31:0]        s1_sq;
  logic [20:0]        pp_d [0:S_P4-1];

  assign d1      = $signed({2'b0, sample.raw_temperature[19:3]}) - $signed({2'b0, t1, 1'b0});
  assign d2      = $signed({2'b0, sample.raw_temperature[19:4]}) - $signed({2'b0, t1});
  assign m1_full = d1 * t2;
  assign sq_full = d2 * d2;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m1   <= m1_full[31:0];
      s1_sq   <= sq_full[31:0];
      pp_d[0] <= ptc_pkg::PRESS_FULL - {1'b0, sample.raw_pressure};
    end
  end

  genvar k;
  generate
    for (k = 1; k < S_P4; k++) begin : g_pp
      always_ff @(posedge clk) begin
        if (en) begin
          pp_d[k] <= pp_d[k-1];
        end
      end
    end
  endgenerate

  // temperature stage 2
  logic signed [31:0] sq_sh;
  logic signed [47:0] x_full;
  logic signed [31:0] v1_sh;
  logic [31:0]        s2_v1;
  logic [31:0]        s2_x;

  assign sq_sh  = $signed(s1_sq) >>> 12;
  assign x_full = sq_sh * t3;
  assign v1_sh  = $signed(s1_m1) >>> 11;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_v1 <= v1_sh;
      s2_x  <= x_full[31:0];
    end
  end

  // temperature stage 3: fine temperature
  logic signed [31:0] v2_sh;
  logic [31:0]        fine;

  assign v2_sh = $signed(s2_x) >>> 14;

  always_ff @(posedge clk) begin
    if (en) begin
      fine <= s2_v1 + v2_sh;
    end
  end

  // temperature stage 4: centi degrees and pressure offset
  logic [31:0]        f5;
  logic signed [31:0] temp_sh;
  logic signed [32:0] a_off;
  logic signed [32:0] s4_a;
  logic [31:0]        temp_d [S_T4:NST-1];

  assign f5      = fine + {fine[29:0], 2'b0} + 32'd128;
  assign temp_sh = $signed(f5) >>> 8;
  assign a_off   = $signed({fine[31], fine}) - ptc_pkg::TEMP_OFFSET;

  always_ff @(posedge clk) begin
    if (en) begin
      temp_d[S_T4] <= temp_sh;
      s4_a         <= a_off;
    end
  end

  generate
    for (k = S_T4 + 1; k < NST; k++) begin : g_temp
      always_ff @(posedge clk) begin
        if (en) begin
          temp_d[k] <= temp_d[k-1];
        end
      end
    end
  endgenerate

  // pressure stage 1: square and linear terms
  logic signed [65:0] aa_full;
  logic signed [48:0] ap5_full;
  logic signed [48:0] ap2_full;
  logic [63:0]        s5_aa;
  logic signed [48:0] s5_ap5;
  logic signed [48:0] s5_ap2;

  assign aa_full  = s4_a * s4_a;
  assign ap5_full = s4_a * p5;
  assign ap2_full = s4_a * p2;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_aa  <= aa_full[63:0];
      s5_ap5 <= ap5_full;
      s5_ap2 <= ap2_full;
    end
  end

  // pressure stage 2: square times coefficients
  logic signed [79:0] b1_full;
  logic signed [79:0] c_full;
  logic [63:0]        s6_b1;
  logic [63:0]        s6_c;
  logic signed [48:0] s6_ap5;
  logic signed [48:0] s6_ap2;

  assign b1_full = $signed(s5_aa) * p6;
  assign c_full  = $signed(s5_aa) * p3;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_b1  <= b1_full[63:0];
      s6_c   <= c_full[63:0];
      s6_ap5 <= s5_ap5;
      s6_ap2 <= s5_ap2;
    end
  end

  // pressure stage 3: sums
  logic [63:0]        ap5_x;
  logic [63:0]        ap2_x;
  logic [63:0]        p4_x;
  logic signed [63:0] c_sh;
  logic [63:0]        s7_b;
  logic [63:0]        s7_a;

  assign ap5_x = {{15{s6_ap5[48]}}, s6_ap5};
  assign ap2_x = {{15{s6_ap2[48]}}, s6_ap2};
  assign p4_x  = {{48{p4[15]}}, p4};
  assign c_sh  = $signed(s6_c) >>> 8;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_b <= s6_b1 + {ap5_x[46:0], 17'b0} + {p4_x[28:0], 35'b0};
      s7_a <= c_sh + {ap2_x[51:0], 12'b0};
    end
  end

  // pressure stage 4: divisor product and dividend base
  logic [63:0] am_base;
  logic [79:0] am_full;
  logic [63:0] s8_am;
  logic [63:0] s8_num;

  assign am_base = ptc_pkg::PRESS_ONE + s7_a;
  assign am_full = am_base * p1;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_am  <= am_full[63:0];
      s8_num <= {12'b0, pp_d[S_P4-1], 31'b0} - s7_b;
    end
  end

  // pressure stage 5: scale dividend, take divisor
  logic [75:0] num_full;
  logic [30:0] s9_dv;
  logic [63:0] s9_num;

  assign num_full = s8_num * ptc_pkg::PRESS_SCALE;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_dv  <= s8_am[63:ptc_pkg::DIV_SHIFT];
      s9_num <= num_full[63:0];
    end
  end

  // pressure stage 6: magnitudes and signs, divider entry
  logic [30:0] rem_d [S_P6:S_DL];
  logic [63:0] nq_d  [S_P6:S_DL];
  logic [30:0] mb_d  [S_P6:S_DL];
  logic        neg_d [S_P6:S_DL];
  logic        inv_d [S_P6:NST-1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_d[S_P6] <= '0;
      nq_d[S_P6]  <= s9_num[63] ? -s9_num : s9_num;
      mb_d[S_P6]  <= s9_dv[30] ? -s9_dv : s9_dv;
      neg_d[S_P6] <= s9_num[63] ^ s9_dv[30];
      inv_d[S_P6] <= (s9_dv == '0);
    end
  end

  // restoring divider, one quotient bit per stage
  generate
    for (k = S_D0; k <= S_DL; k++) begin : g_div
      logic [31:0] trial;
      logic [31:0] diff;
      logic        ge;
      assign trial = {rem_d[k-1], nq_d[k-1][63]};
      assign diff  = trial - {1'b0, mb_d[k-1]};
      assign ge    = trial >= {1'b0, mb_d[k-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_d[k] <= ge ? diff[30:0] : trial[30:0];
          nq_d[k]  <= {nq_d[k-1][62:0], ge};
          mb_d[k]  <= mb_d[k-1];
          neg_d[k] <= neg_d[k-1];
        end
      end
    end
    for (k = S_D0; k < NST; k++) begin : g_inv
      always_ff @(posedge clk) begin
        if (en) begin
          inv_d[k] <= inv_d[k-1];
        end
      end
    end
  endgenerate

  // correction stage 1: signed quotient
  logic [63:0] q1_p;

  always_ff @(posedge clk) begin
    if (en) begin
      q1_p <= neg_d[S_DL] ? -nq_d[S_DL] : nq_d[S_DL];
    end
  end

  // correction stage 2: partial products of the square, p8 term
  logic signed [63:0] q_sh;
  logic [63:0]        ll_full;
  logic [63:0]        cr_full;
  logic signed [79:0] c2_full;
  logic [63:0]        q2_ll;
  logic [31:0]        q2_cr;
  logic [63:0]        q2_c2;
  logic [63:0]        q2_p;

  assign q_sh    = $signed(q1_p) >>> 13;
  assign ll_full = q_sh[31:0] * q_sh[31:0];
  assign cr_full = q_sh[63:32] * q_sh[31:0];
  assign c2_full = $signed(q1_p) * p8;

  always_ff @(posedge clk) begin
    if (en) begin
      q2_ll <= ll_full;
      q2_cr <= cr_full[31:0];
      q2_c2 <= c2_full[63:0];
      q2_p  <= q1_p;
    end
  end

  // correction stage 3: square
  logic [63:0] q3_qq;
  logic [63:0] q3_c2;
  logic [63:0] q3_p;

  always_ff @(posedge clk) begin
    if (en) begin
      q3_qq <= q2_ll + {q2_cr[30:0], 1'b0, 32'b0};
      q3_c2 <= q2_c2;
      q3_p  <= q2_p;
    end
  end

  // correction stage 4: p9 term
  logic signed [79:0] c1_full;
  logic [63:0]        q4_c1;
  logic [63:0]        q4_c2;
  logic [63:0]        q4_p;

  assign c1_full = $signed(q3_qq) * p9;

  always_ff @(posedge clk) begin
    if (en) begin
      q4_c1 <= c1_full[63:0];
      q4_c2 <= q3_c2;
      q4_p  <= q3_p;
    end
  end

  // correction stage 5: sum
  logic signed [63:0] c1_sh;
  logic signed [63:0] c2_sh;
  logic [63:0]        q5_sum;

  assign c1_sh = $signed(q4_c1) >>> 25;
  assign c2_sh = $signed(q4_c2) >>> 19;

  always_ff @(posedge clk) begin
    if (en) begin
      q5_sum <= q4_p + c1_sh + c2_sh;
    end
  end

  // output register
  logic signed [63:0] sum_sh;
  logic [31:0]        p7_x;
  logic [31:0]        press;

  assign sum_sh = $signed(q5_sum) >>> 8;
  assign p7_x   = {{12{p7[15]}}, p7, 4'b0};
  assign press  = sum_sh[31:0] + p7_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_move) begin
      res_valid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && vld[NST-1]) begin
      result.temperature_centi <= $signed(temp_d[NST-1]);
      result.pressure_q24_8    <= inv_d[NST-1] ? '0 : press;
      result.pressure_invalid  <= inv_d[NST-1];
    end
  end

endmodule
